// ===== src/sppm_pkg.sv =====
// ----------------------------------------------------------------------------
// sppm_pkg: shared types and constants of the servo PPM frame generator
// Holds field widths, reset values, request modes, register indexes and
// the structures passed between the modules of the block.
// ----------------------------------------------------------------------------
package sppm_pkg;

   // Default number of servo channels.
   localparam int CHANNELS_DEFAULT = 8;

   // Fixed field widths.
   localparam int MODE_W    = 2;
   localparam int CHAN_W    = 3;
   localparam int VALUE_W   = 16;
   localparam int LINES_W   = 8;
   localparam int SLOT_OUT_W = 4;
   localparam int FRAME_W   = 16;
   localparam int SYNC_W    = 12;
   localparam int TICK_W    = 16;
   localparam int TOTAL_W   = 20;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Reset values in ticks of 0.5 us.
   localparam logic [FRAME_W-1:0] FRAME_RESET = 16'd40000;
   localparam logic [SYNC_W-1:0]  SYNC_RESET  = 12'd500;
   localparam logic [VALUE_W-1:0] WIDTH_RESET = 16'd3000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LENGTH  = 1'd1;

   // Request modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 2'd0,
      MODE_RECV    = 2'd1,
      MODE_RAW     = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   // Configuration register contents.
   typedef struct packed {
      logic [FRAME_W-1:0] frame_length;
      logic [SYNC_W-1:0]  sync_length;
   } cfg_type;

   // Write request into the channel width store.
   typedef struct packed {
      logic               en;
      logic [CHAN_W-1:0]  channel;
      logic [VALUE_W-1:0] data;
   } width_wr_type;

   // One result transaction.
   typedef struct packed {
      logic               ppm_level;
      logic [LINES_W-1:0] servo_lines;
      logic [SLOT_OUT_W-1:0] slot;
      logic               frame_start;
      logic               gap_short;
      logic               running;
   } rsp_type;

endpackage

// ===== src/sppm_width_regs.sv =====
// ----------------------------------------------------------------------------
// sppm_width_regs: channel width store
// One width register per channel, reset to the default servo width, with a
// single write port and a combinational read port indexed by slot number.
// ----------------------------------------------------------------------------
module sppm_width_regs
   import sppm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   parameter int SLOT_W   = $clog2(CHANNELS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  width_wr_type       wr,
   input  logic [SLOT_W-1:0]  rd_idx,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] width_ff [CHANNELS];

   // Write port: channels at or above CHANNELS never match and are dropped.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            width_ff[i] <= WIDTH_RESET;
         end else if (wr.en && (int'(wr.channel) == i)) begin
            width_ff[i] <= wr.data;
         end
      end
   end

   // Read port: an index outside the store reads as zero.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(rd_idx) == i) begin
            rd_data = width_ff[i];
         end
      end
   end

endmodule

// ===== src/sppm_slot_engine.sv =====
// ----------------------------------------------------------------------------
// sppm_slot_engine: slot sequencer and result logic
// Keeps the slot counters and running frame sum, applies one request per
// transaction and forms the result fields from the state after it.
// ----------------------------------------------------------------------------
module sppm_slot_engine
   import sppm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [MODE_W-1:0]  mode,
   input  logic [CHAN_W-1:0]  channel,
   input  logic [VALUE_W-1:0] value,
   input  cfg_type            cfg,
   output rsp_type            rsp
);

   localparam int SLOT_W = $clog2(CHANNELS + 1);
   localparam logic [SLOT_W-1:0] GAP_SLOT = SLOT_W'(CHANNELS);

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TICK_W-1:0]  left_ff, left_in;
   logic [TICK_W-1:0]  into_ff, into_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               active_ff, active_in;
   logic               floored_ff, floored_in;

   mode_type           mode_q;
   width_wr_type       wr;
   logic [SLOT_W-1:0]  next_slot;
   logic [TOTAL_W-1:0] base_total;
   logic [VALUE_W-1:0] width_rd;
   logic [TICK_W-1:0]  width_len;
   logic [SYNC_W-1:0]  sync_len;
   logic [TOTAL_W-1:0] frame_ext;
   logic               boundary;
   logic               ppm;
   logic [LINES_W-1:0] lines;
   logic               fstart;
   logic [SLOT_W-1:0]  slot_cur;
   logic [TICK_W-1:0]  left_cur;
   logic [TICK_W-1:0]  into_cur;

   assign mode_q = mode_type'(mode);

   // Width writes: received values are stored doubled, raw widths as given.
   always_comb begin
      wr.en      = fire && ((mode_q == MODE_RECV) || (mode_q == MODE_RAW));
      wr.channel = channel;
      wr.data    = (mode_q == MODE_RECV) ? {value[VALUE_W-2:0], 1'b0} : value;
   end

   // Slot that the next boundary opens and the frame sum it starts from.
   always_comb begin
      if (slot_ff >= GAP_SLOT) begin
         next_slot  = '0;
         base_total = '0;
      end else begin
         next_slot  = slot_ff + SLOT_W'(1);
         base_total = total_ff;
      end
   end

   sppm_width_regs #(
      .CHANNELS (CHANNELS),
      .SLOT_W   (SLOT_W)
   ) u_width_regs (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_idx  (next_slot),
      .rd_data (width_rd)
   );

   // A zero width or zero sync still gives a slot of one tick.
   assign width_len = (width_rd == '0) ? TICK_W'(1) : width_rd;
   assign sync_len  = (cfg.sync_length == '0) ? SYNC_W'(1) : cfg.sync_length;
   assign frame_ext = TOTAL_W'(cfg.frame_length);

   // Next state and result fields.
   always_comb begin
      slot_in    = slot_ff;
      left_in    = left_ff;
      into_in    = into_ff;
      total_in   = total_ff;
      active_in  = active_ff;
      floored_in = floored_ff;
      boundary   = 1'b0;
      ppm        = 1'b0;
      lines      = '0;
      fstart     = 1'b0;
      slot_cur   = slot_ff;
      left_cur   = left_ff;
      into_cur   = into_ff;

      unique case (mode_q)
         MODE_TICK: begin
            if (active_ff) begin
               boundary = (left_ff == '0);
               if (boundary) begin
                  slot_cur = next_slot;
                  into_cur = '0;
                  if (next_slot < GAP_SLOT) begin
                     left_cur   = width_len;
                     total_in   = base_total + TOTAL_W'(width_len);
                     floored_in = 1'b0;
                  end else if (base_total >= frame_ext) begin
                     left_cur   = TICK_W'(sync_len);
                     total_in   = base_total;
                     floored_in = 1'b1;
                  end else begin
                     left_cur   = cfg.frame_length - base_total[TICK_W-1:0];
                     total_in   = base_total;
                     floored_in = 1'b0;
                  end
                  fstart = (next_slot == '0);
               end
               ppm = (into_cur < TICK_W'(cfg.sync_length));
               for (int b = 0; b < LINES_W; b++) begin
                  lines[b] = (int'(slot_cur) == b) && (b < CHANNELS);
               end
               slot_in = slot_cur;
               into_in = (into_cur == '1) ? into_cur : into_cur + TICK_W'(1);
               left_in = left_cur - TICK_W'(1);
            end
         end
         MODE_RECV, MODE_RAW: begin
            // Width store write only; counters hold.
         end
         MODE_RESTART: begin
            // Park at the end of a gap so the next tick opens slot 0.
            active_in  = 1'b1;
            slot_in    = GAP_SLOT;
            left_in    = '0;
            into_in    = '0;
            total_in   = '0;
            floored_in = 1'b0;
         end
         default: begin
         end
      endcase

      rsp.ppm_level   = ppm;
      rsp.servo_lines = lines;
      rsp.slot        = SLOT_OUT_W'(slot_in);
      rsp.frame_start = fstart;
      rsp.gap_short   = floored_in && (slot_in == GAP_SLOT);
      rsp.running     = active_in;
   end

   // State registers advance once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         left_ff    <= '0;
         into_ff    <= '0;
         total_ff   <= '0;
         active_ff  <= 1'b0;
         floored_ff <= 1'b0;
      end else if (fire) begin
         slot_ff    <= slot_in;
         left_ff    <= left_in;
         into_ff    <= into_in;
         total_ff   <= total_in;
         active_ff  <= active_in;
         floored_ff <= floored_in;
      end
   end

endmodule

// ===== src/servo_ppm_frame_generator.sv =====
// ----------------------------------------------------------------------------
// servo_ppm_frame_generator: PPM frame and servo line generator
// Produces a repeating frame of servo slots and a closing gap, one tick per
// tick transaction, with channel width writes and frame restart requests.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction  Handshake
//   request   req_mode/channel/value         in         req_valid/req_ready
//   response  rsp_ppm_level .. rsp_running   out        rsp_valid/rsp_ready
//   config    csr_index/csr_wdata            in         csr_we, no wait
//
// An accepted request is held in the input register, which feeds the
// slot engine; the engine's result is captured in the output register,
// which presents it as the response. A new request is accepted every
// cycle while responses drain. A stalled response holds the pipeline;
// the input register still takes one more request. Synchronous reset
// clears the counters, sets all channel widths to 3000 ticks, frame
// length to 40000 and sync length to 500.
//
module servo_ppm_frame_generator
   import sppm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ppm_level,
   output logic [LINES_W-1:0]    rsp_servo_lines,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_frame_start,
   output logic                  rsp_gap_short,
   output logic                  rsp_running,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg_ff;
   logic               in_valid_ff, in_valid_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [CHAN_W-1:0]  channel_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               take;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length <= FRAME_RESET;
         cfg_ff.sync_length  <= SYNC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH: cfg_ff.frame_length <= csr_wdata[FRAME_W-1:0];
            CSR_SYNC_LENGTH:  cfg_ff.sync_length  <= csr_wdata[SYNC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the engine takes the held transaction when the output
   // register is empty or being drained.
   assign take         = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || take;
   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (take ? 1'b0 : in_valid_ff);
   assign out_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff    <= req_mode;
         channel_ff <= req_channel;
         value_ff   <= req_value;
      end
   end

   sppm_slot_engine #(
      .CHANNELS (CHANNELS)
   ) u_slot_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (take),
      .mode    (mode_ff),
      .channel (channel_ff),
      .value   (value_ff),
      .cfg     (cfg_ff),
      .rsp     (rsp_in)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_ppm_level   = rsp_ff.ppm_level;
   assign rsp_servo_lines = rsp_ff.servo_lines;
   assign rsp_slot        = rsp_ff.slot;
   assign rsp_frame_start = rsp_ff.frame_start;
   assign rsp_gap_short   = rsp_ff.gap_short;
   assign rsp_running     = rsp_ff.running;

endmodule
